[hw/rtl/mnb_pkg.sv]
// Shared types, constants and log2 fraction table for the naive Bayes block.
package mnb_pkg;

  localparam int XW = 37;
  localparam int PBW = 6;
  localparam int SW = 56;

  localparam logic [2:0] ADDR_ALPHA = 3'd0;
  localparam logic OP_TRAIN = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic signed [47:0] S48MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48MIN = 48'sh8000_0000_0000;

  typedef logic [15:0] frac_tab_t [256];

  // round(65536*log2(1+m/256)) by repeated squaring, elaboration only
  function automatic logic [15:0] frac_entry(input int unsigned m);
    logic [63:0] x;
    logic [127:0] pr;
    logic [63:0] r;
    x = 64'(256 + m) << 53;
    r = '0;
    for (int i = 0; i < 40; i++) begin
      pr = 128'(x) * 128'(x);
      x = pr[124:61];
      r = r << 1;
      if (x >= 64'h4000_0000_0000_0000) begin
        x = x >> 1;
        r[0] = 1'b1;
      end
    end
    return 16'((r + 64'h80_0000) >> 24);
  endfunction

  function automatic frac_tab_t frac_table();
    frac_tab_t t;
    for (int m = 0; m < 256; m++) begin
      t[m] = frac_entry(m);
    end
    return t;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [SW-1:0] v);
    if (v > SW'(S48MAX)) begin
      return S48MAX;
    end else if (v < SW'(S48MIN)) begin
      return S48MIN;
    end
    return v[47:0];
  endfunction

endpackage

[hw/rtl/mnb_log2.sv]
// Fixed point log2: msb position plus fraction table lookup.
module mnb_log2 #(
  parameter int LOG_FRACTION_BITS = 16
) (
  input  logic [mnb_pkg::XW-1:0]                    x_i,
  output logic [mnb_pkg::PBW+LOG_FRACTION_BITS-1:0] y_o
);
  import mnb_pkg::*;

  localparam int LW = PBW + LOG_FRACTION_BITS;
  localparam frac_tab_t FracTab = frac_table();

  logic [PBW-1:0] p;
  logic [7:0]     m;
  logic [15:0]    t;
  logic [LW-1:0]  ts;

  always_comb begin
    p = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) begin
        p = PBW'(i);
      end
    end
    if (p >= PBW'(8)) begin
      m = 8'(x_i >> (p - PBW'(8)));
    end else begin
      m = 8'(x_i << (PBW'(8) - p));
    end
    t = FracTab[m];
  end

  if (LOG_FRACTION_BITS >= 16) begin : g_up
    assign ts = LW'(t) << (LOG_FRACTION_BITS - 16);
  end else begin : g_dn
    localparam int SH = 16 - LOG_FRACTION_BITS;
    logic [16:0] tr;
    assign tr = 17'(t) + 17'(1 << (SH - 1));
    assign ts = LW'(tr >> SH);
  end

  assign y_o = (x_i == '0) ? '0 : ({p, LOG_FRACTION_BITS'(0)} + ts);

endmodule

[hw/rtl/multinomial_naive_bayes.sv]
// Top level: online multinomial naive Bayes classifier.
// Usage:
//   Items enter on start when busy is low; one item is one feature
//   element (opcode, class_label, feature_value, last).
//   A train item steps through read, write and end states; a classify item
//   runs read, log2, multiply and accumulate for each class, then the end
//   state; an item past the feature limit goes straight to the end state.
//   A classify item with last set then runs a closing pass (four steps
//   per trained class, one per untrained class; one shared log2 unit and
//   one multiplier, used once per step) and pulses result_valid_o for one
//   cycle right after it; busy drops with the strobe.
//   Train items and other classify items give no result.
//   Results cannot be stalled: they are valid for exactly one cycle.
//   After reset the count memory is cleared, one entry a cycle, with busy
//   high; APB writes of smoothing_alpha (address 0) are taken at any time.
module multinomial_naive_bayes #(
  parameter int NUM_CLASSES = 8,
  parameter int MAX_FEATURES = 64,
  parameter int LOG_FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [2:0]  class_label_i,
  input  logic [15:0] feature_value_i,
  input  logic        last_i,
  output logic        result_valid_o,
  output logic [2:0]  predicted_class_o,
  output logic        no_class_o,
  output logic signed [47:0] best_score_o
);
  import mnb_pkg::*;

  localparam int DEPTH = NUM_CLASSES * MAX_FEATURES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int PW = $clog2(MAX_FEATURES + 1);
  localparam int NW = PW + 8;
  localparam int LW = PBW + LOG_FRACTION_BITS;
  localparam int PRW = 24 + LW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_TRD, S_TWR, S_CRD, S_CLOG, S_CMUL, S_CACC,
    S_END, S_FLT, S_FLD, S_FMUL, S_FLC, S_FCMP
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic [7:0] alpha_q;
  logic op_q, last_q, taken_q;
  logic [2:0] lab_q;
  logic [15:0] f_q;
  logic [PW-1:0] pos_q;
  logic [CW-1:0] c_q;
  logic [31:0] tot_q [NUM_CLASSES];
  logic [23:0] smp_q [NUM_CLASSES];
  logic [23:0] all_q;
  logic signed [47:0] acc_q [NUM_CLASSES];
  logic [23:0] sum_q;
  logic [LW-1:0] lg_q, lt_q;
  logic [PRW-1:0] prod_q;
  logic [NW-1:0] na_q;
  logic found_q;
  logic [CW-1:0] best_c_q;
  logic signed [47:0] best_q;
  logic valid_q, no_class_q;
  logic [2:0] pc_q;
  logic signed [47:0] score_out_q;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  logic [7:0] a_eff;
  logic lab_ok;
  logic [AW-1:0] rd_addr, cls_addr;
  logic [XW-1:0] log_x;
  logic [LW-1:0] log_y;
  logic [23:0] mul_a;
  logic [PRW-1:0] prod;
  logic signed [47:0] acc_new, prod_sat, score;
  logic win;
  logic [32:0] cnt_sum, tot_sum;
  logic [PW-1:0] n_el;
  logic accept, last_c;

  assign a_eff = (alpha_q == 8'd0) ? 8'd1 : alpha_q;
  assign lab_ok = 32'(lab_q) < NUM_CLASSES;
  assign cls_addr = AW'(32'(c_q) * MAX_FEATURES + 32'(pos_q));
  assign rd_addr = (state_q == S_TRD || state_q == S_TWR) ?
                   AW'(32'(CW'(lab_q)) * MAX_FEATURES + 32'(pos_q)) : cls_addr;
  assign last_c = (32'(c_q) == NUM_CLASSES - 1);
  assign accept = start && (state_q == S_IDLE);
  assign n_el = taken_q ? (pos_q + PW'(1)) : PW'(MAX_FEATURES);

  always_comb begin
    case (state_q)
      S_CLOG:  log_x = {1'b0, rdata_q, 4'b0} + XW'(a_eff);
      S_FLD:   log_x = {1'b0, tot_q[c_q], 4'b0} + XW'(na_q);
      S_FLC:   log_x = XW'(smp_q[c_q]);
      S_FLT:   log_x = XW'(all_q);
      default: log_x = '0;
    endcase
  end

  mnb_log2 #(.LOG_FRACTION_BITS(LOG_FRACTION_BITS)) u_log2 (
    .x_i(log_x),
    .y_o(log_y)
  );

  assign mul_a = (state_q == S_CMUL) ? 24'(f_q) : sum_q;
  assign prod = PRW'(mul_a) * PRW'(lg_q);

  assign acc_new = sat48(SW'(acc_q[c_q]) + $signed(SW'(prod_q)));
  assign prod_sat = (64'(prod_q) > 64'(S48MAX)) ? S48MAX : 48'(prod_q);
  assign score = sat48(SW'(acc_q[c_q]) - SW'(prod_sat)
                       + $signed(SW'(lg_q)) - $signed(SW'(lt_q)));
  assign win = !found_q || (score > best_q);

  assign cnt_sum = 33'(rdata_q) + 33'(f_q);
  assign tot_sum = 33'(tot_q[CW'(lab_q)]) + 33'(f_q);

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    if (state_q == S_CLR) begin
      mem[clr_q] <= '0;
    end else if (state_q == S_TWR) begin
      mem[rd_addr] <= cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ALPHA) ? {24'd0, alpha_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 8'd16;
    end else if (psel && penable && pwrite && paddr == ADDR_ALPHA) begin
      alpha_q <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      op_q <= OP_TRAIN;
      last_q <= 1'b0;
      taken_q <= 1'b0;
      lab_q <= '0;
      f_q <= '0;
      pos_q <= '0;
      c_q <= '0;
      all_q <= '0;
      sum_q <= '0;
      lg_q <= '0;
      lt_q <= '0;
      prod_q <= '0;
      na_q <= '0;
      found_q <= 1'b0;
      best_c_q <= '0;
      best_q <= '0;
      valid_q <= 1'b0;
      no_class_q <= 1'b0;
      pc_q <= '0;
      score_out_q <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        tot_q[i] <= '0;
        smp_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (32'(clr_q) == DEPTH - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q <= opcode_i;
            lab_q <= class_label_i;
            f_q <= feature_value_i;
            last_q <= last_i;
            taken_q <= 32'(pos_q) < MAX_FEATURES;
            c_q <= '0;
            if (32'(pos_q) >= MAX_FEATURES) begin
              state_q <= S_END;
            end else if (opcode_i == OP_CLASSIFY) begin
              state_q <= S_CRD;
            end else if (32'(class_label_i) < NUM_CLASSES) begin
              state_q <= S_TRD;
            end else begin
              state_q <= S_END;
            end
          end
        end
        S_TRD: state_q <= S_TWR;
        S_TWR: begin
          tot_q[CW'(lab_q)] <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
          state_q <= S_END;
        end
        S_CRD: state_q <= S_CLOG;
        S_CLOG: begin
          lg_q <= log_y;
          state_q <= S_CMUL;
        end
        S_CMUL: begin
          prod_q <= prod;
          state_q <= S_CACC;
        end
        S_CACC: begin
          acc_q[c_q] <= acc_new;
          if (last_c) begin
            sum_q <= ((25'(sum_q) + 25'(f_q)) > 25'hFF_FFFF) ? 24'hFF_FFFF
                     : sum_q + 24'(f_q);
            state_q <= S_END;
          end else begin
            c_q <= c_q + CW'(1);
            state_q <= S_CRD;
          end
        end
        S_END: begin
          if (op_q == OP_TRAIN && last_q && lab_ok) begin
            if (smp_q[CW'(lab_q)] != 24'hFF_FFFF) begin
              smp_q[CW'(lab_q)] <= smp_q[CW'(lab_q)] + 24'd1;
            end
            if (all_q != 24'hFF_FFFF) begin
              all_q <= all_q + 24'd1;
            end
          end
          if (!last_q) begin
            if (taken_q) begin
              pos_q <= pos_q + PW'(1);
            end
            state_q <= S_IDLE;
          end else if (op_q == OP_CLASSIFY) begin
            state_q <= S_FLT;
          end else begin
            pos_q <= '0;
            sum_q <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              acc_q[i] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_FLT: begin
          lt_q <= log_y;
          na_q <= NW'(n_el) * NW'(a_eff);
          c_q <= '0;
          found_q <= 1'b0;
          best_c_q <= '0;
          best_q <= '0;
          state_q <= S_FLD;
        end
        S_FLD: begin
          if (smp_q[c_q] == 24'd0) begin
            if (last_c) begin
              valid_q <= 1'b1;
              no_class_q <= !found_q;
              pc_q <= 3'(best_c_q);
              score_out_q <= best_q;
              pos_q <= '0;
              sum_q <= '0;
              for (int i = 0; i < NUM_CLASSES; i++) begin
                acc_q[i] <= '0;
              end
              state_q <= S_IDLE;
            end else begin
              c_q <= c_q + CW'(1);
            end
          end else begin
            lg_q <= log_y;
            state_q <= S_FMUL;
          end
        end
        S_FMUL: begin
          prod_q <= prod;
          state_q <= S_FLC;
        end
        S_FLC: begin
          lg_q <= log_y;
          state_q <= S_FCMP;
        end
        S_FCMP: begin
          if (win) begin
            found_q <= 1'b1;
            best_c_q <= c_q;
            best_q <= score;
          end
          if (last_c) begin
            valid_q <= 1'b1;
            no_class_q <= 1'b0;
            pc_q <= win ? 3'(c_q) : 3'(best_c_q);
            score_out_q <= win ? score : best_q;
            pos_q <= '0;
            sum_q <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              acc_q[i] <= '0;
            end
            state_q <= S_IDLE;
          end else begin
            c_q <= c_q + CW'(1);
            state_q <= S_FLD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign predicted_class_o = pc_q;
  assign no_class_o = no_class_q;
  assign best_score_o = score_out_q;

`ifndef SYNTHESIS
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held");
  a_clr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> busy) else $error("ready during clear");
  a_noclass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && no_class_o) |-> (predicted_class_o == 3'd0 && best_score_o == 48'sd0))
    else $error("bad empty result");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= MAX_FEATURES) else $error("position overrun");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the multinomial naive Bayes classifier.
module tb_top;
  import mnb_pkg::*;

  typedef struct packed {
    logic        op;
    logic [2:0]  lab;
    logic [15:0] val;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [2:0]         cls;
    logic               none;
    logic signed [47:0] score;
  } verdict_t;

  localparam int NCLS = 8;
  localparam int NFEAT = 64;
  localparam longint S48_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint S48_LO = -S48_HI - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic op_r = 1'b0;
  logic [2:0] lab_r = '0;
  logic [15:0] val_r = '0;
  logic last_r = 1'b0;
  logic result_valid_o;
  logic [2:0] predicted_class_o;
  logic no_class_o;
  logic signed [47:0] best_score_o;

  multinomial_naive_bayes uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .opcode_i(op_r), .class_label_i(lab_r), .feature_value_i(val_r), .last_i(last_r),
    .result_valid_o(result_valid_o), .predicted_class_o(predicted_class_o),
    .no_class_o(no_class_o), .best_score_o(best_score_o)
  );

  // classifier shadow state
  logic [15:0] log_frac [256];
  logic [7:0] alpha_q = 8'd16;
  logic [31:0] feat_cnt [NCLS][NFEAT];
  logic [31:0] class_tot [NCLS];
  logic [23:0] class_smp [NCLS];
  logic [23:0] all_smp;
  int unsigned elem_pos;
  longint score_acc [NCLS];
  logic [23:0] val_sum;

  elem_t pend_q [$];
  verdict_t verdict_q [$];
  int n_items = 0, n_results = 0, n_bad = 0;
  int burst_left = 0, gap_left = 0;
  elem_t cur;

  initial forever #6 clk_i = ~clk_i;

  function automatic logic [15:0] calc_frac(int unsigned m);
    logic [63:0] x;
    logic [127:0] sq;
    logic [63:0] r;
    x = 64'(256 + m) << 53;
    r = 0;
    for (int i = 0; i < 40; i++) begin
      sq = {64'd0, x} * {64'd0, x};
      x = sq[124:61];
      r = r << 1;
      if (x[63:62] != 0) begin
        x = x >> 1;
        r[0] = 1'b1;
      end
    end
    return 16'((r + 64'd8388608) >> 24);
  endfunction

  function automatic longint log2_q16(longint unsigned x);
    int p;
    longint unsigned m;
    if (x == 0) return 0;
    p = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p >= 8) m = (x >> (p - 8)) & 255;
    else m = (x << (8 - p)) & 255;
    return (longint'(p) << 16) + longint'(log_frac[m]);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > S48_HI) return S48_HI;
    if (v < S48_LO) return S48_LO;
    return v;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > lim) ? lim : s[31:0];
  endfunction

  function automatic void clear_shadow();
    for (int c = 0; c < NCLS; c++) begin
      for (int k = 0; k < NFEAT; k++) feat_cnt[c][k] = 0;
      class_tot[c] = 0;
      class_smp[c] = 0;
      score_acc[c] = 0;
    end
    all_smp = 0;
    elem_pos = 0;
    val_sum = 0;
  endfunction

  function automatic void classify_step(elem_t e);
    bit taken;
    longint unsigned a, n;
    longint s, top;
    bit found;
    logic [2:0] win;
    verdict_t v;
    taken = elem_pos < NFEAT;
    a = (alpha_q == 0) ? 1 : alpha_q;
    if (e.op == OP_TRAIN) begin
      if (taken) begin
        feat_cnt[e.lab][elem_pos] = sat_add(feat_cnt[e.lab][elem_pos], e.val, 32'hFFFF_FFFF);
        class_tot[e.lab] = sat_add(class_tot[e.lab], e.val, 32'hFFFF_FFFF);
      end
      if (e.last) begin
        class_smp[e.lab] = 24'(sat_add(class_smp[e.lab], 1, 32'hFF_FFFF));
        all_smp = 24'(sat_add(all_smp, 1, 32'hFF_FFFF));
      end
    end else if (taken) begin
      for (int c = 0; c < NCLS; c++)
        score_acc[c] = clamp48(score_acc[c] + longint'(e.val) *
                       log2_q16(longint'(feat_cnt[c][elem_pos]) * 16 + a));
      val_sum = 24'(sat_add(val_sum, e.val, 32'hFF_FFFF));
    end
    if (!e.last) begin
      if (taken) elem_pos++;
      return;
    end
    if (e.op == OP_CLASSIFY) begin
      n = taken ? elem_pos + 1 : NFEAT;
      found = 0;
      win = 0;
      top = 0;
      for (int c = 0; c < NCLS; c++) begin
        if (class_smp[c] == 0) continue;
        s = score_acc[c] - clamp48(longint'(val_sum) *
            log2_q16(longint'(class_tot[c]) * 16 + n * a));
        s = clamp48(s + log2_q16(class_smp[c]) - log2_q16(all_smp));
        if (!found || s > top) begin
          found = 1;
          win = 3'(c);
          top = s;
        end
      end
      v.cls = win;
      v.none = !found;
      v.score = top[47:0];
      verdict_q = {verdict_q, v};
    end
    elem_pos = 0;
    val_sum = 0;
    for (int c = 0; c < NCLS; c++) score_acc[c] = 0;
  endfunction

  // driver: bursts of items with random gaps
  always @(posedge clk_i) begin
    if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur = pend_q.pop_front();
        op_r <= cur.op;
        lab_r <= cur.lab;
        val_r <= cur.val;
        last_r <= cur.last;
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict from accepted items
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni) begin
      if (result_valid_o) begin
        n_results++;
        got.cls = predicted_class_o;
        got.none = no_class_o;
        got.score = best_score_o;
        if (verdict_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result cls=%0d none=%0d score=%0d",
                                    got.cls, got.none, got.score);
        end else begin
          want = verdict_q.pop_front();
          if (got != want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp cls=%0d none=%0d score=%0d, got cls=%0d none=%0d score=%0d",
                       want.cls, want.none, want.score, got.cls, got.none, got.score);
          end
        end
      end
      if (start && !busy) begin
        n_items++;
        classify_step({op_r, lab_r, val_r, last_r});
      end
    end
  end

  task automatic add_elem(logic op, logic [2:0] lab, logic [15:0] val, logic last);
    elem_t e;
    e.op = op;
    e.lab = lab;
    e.val = val;
    e.last = last;
    pend_q = {pend_q, e};
  endtask

  task automatic add_sample(logic op, logic [2:0] lab, int len, bit wide);
    for (int i = 0; i < len; i++)
      add_elem(op, lab, wide ? 16'($urandom) : 16'($urandom_range(0, 15)), i == len - 1);
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || start || verdict_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_alpha(logic [7:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_ALPHA;
    pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    alpha_q = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(int cnt);
    int pick, len;
    while (cnt > 0) begin
      pick = $urandom_range(0, 9);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      if (pick < 4) begin
        add_sample(OP_TRAIN, 3'($urandom), len, $urandom_range(0, 3) == 0);
      end else if (pick < 8) begin
        add_sample(OP_CLASSIFY, 3'($urandom), len, $urandom_range(0, 3) == 0);
      end else begin
        for (int i = 0; i < len; i++)
          add_elem(1'($urandom), 3'($urandom), 16'($urandom), i == len - 1);
      end
      cnt -= len;
      while (pend_q.size() > 20) @(posedge clk_i);
    end
  endtask

  initial begin
    for (int m = 0; m < 256; m++) log_frac[m] = calc_frac(m);
    clear_shadow();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: untrained classify, extremes, overlong sample, mixed sample
    add_elem(OP_CLASSIFY, 3'd0, 16'hFFFF, 1'b1);
    add_elem(OP_TRAIN, 3'd0, 16'hFFFF, 1'b0);
    add_elem(OP_TRAIN, 3'd0, 16'd0, 1'b1);
    add_elem(OP_TRAIN, 3'd7, 16'd5, 1'b1);
    add_elem(OP_CLASSIFY, 3'd7, 16'hFFFF, 1'b0);
    add_elem(OP_CLASSIFY, 3'd0, 16'd0, 1'b1);
    add_elem(OP_CLASSIFY, 3'd3, 16'd1, 1'b1);
    add_elem(OP_TRAIN, 3'd3, 16'd9, 1'b0);
    add_elem(OP_CLASSIFY, 3'd3, 16'd2, 1'b1);
    add_sample(OP_TRAIN, 3'd5, 68, 1'b0);
    add_sample(OP_CLASSIFY, 3'd0, 68, 1'b0);
    drain();

    set_alpha(8'd0);
    add_elem(OP_CLASSIFY, 3'd0, 16'd3, 1'b0);
    add_elem(OP_CLASSIFY, 3'd0, 16'd7, 1'b1);
    random_phase(80);
    drain();
    set_alpha(8'd255);
    random_phase(100);
    drain();
    set_alpha(8'd1);
    random_phase(100);
    drain();
    set_alpha(8'($urandom_range(2, 254)));
    random_phase(100);
    drain();
    set_alpha(8'd16);
    random_phase(70);
    drain();

    $display("%0d items driven, %0d classification results checked, %0d mismatches",
             n_items, n_results, n_bad);
    $display("alpha swept over 0, 1, 16, 255 and one random value");
    if (n_bad == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
